### hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on the same edge.
`define CCI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked on the following edge.
`define CCI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/cci_pkg.sv
`default_nettype none

package cci_pkg;

	localparam int NUM_GLOBAL_CTX_DEF = 32;
	localparam int NUM_LOCAL_CTX_DEF  = 8;

	localparam int STORE_IDX_W = 6;
	localparam int CTX_W       = 8;
	localparam int TABLE_W     = 64;
	localparam int TOTAL_W     = 32;
	localparam int QP_W        = 6;
	localparam int APB_ADDR_W  = 5;
	localparam int APB_DATA_W  = 64;

	localparam int OUT_FIFO_DEPTH = 4;

	localparam int QP_MAX      = 51;
	localparam int SLOPE_MUL   = 5;
	localparam int SLOPE_BIAS  = 45;
	localparam int OFFSET_BIAS = 16;
	localparam int STATE_MIN   = 1;
	localparam int STATE_MAX   = 126;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_START = 1'b1;

	typedef enum logic [1:0] {
		KIND_I = 2'd0,
		KIND_P = 2'd1,
		KIND_B = 2'd2
	} slice_kind_t;

	typedef enum logic [1:0] {
		REG_INIT_I = 2'd0,
		REG_INIT_P = 2'd1,
		REG_INIT_B = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FLUSH
	} seq_state_t;

	typedef struct packed {
		logic [CTX_W-1:0] ctx_state;
		logic             last;
	} res_word_t;

endpackage

`default_nettype wire

### hw/rtl/cabac_context_initializer.sv
`default_nettype none

`include "assert_macros.svh"

// CABAC context initializer. Input words with op=0 write one byte of the
// global context store (index past NUM_GLOBAL_CTX ignored) and produce
// no result. A word with op=1 starts a run: on a first slice it emits
// NUM_LOCAL_CTX states computed from the I/P/B init table (P and B swapped by
// swap_init_flag, QP clipped to 0..51); otherwise it replays the NUM_GLOBAL_CTX
// stored bytes. The last word of a run has last_of_run set; emitted_total is
// the 32-bit wrapping count of words emitted including this one. Results
// leave at one per cycle while credit allows and out_ready does not stall,
// through a synchronous store read (or table byte select) and a registered
// slope*QP multiply. After the last issue the pipe drains, and only then is
// the next input word taken, later still if out_ready stalls. A 4-entry
// output queue with credit-based issue absorbs back-pressure. The store is
// cleared at reset by per-entry valid bits, so there is no clearing pass.
// Init tables live at APB byte addresses 0x00 (I), 0x08 (P), 0x10 (B),
// 64 bits each.
module cabac_context_initializer #(
	parameter int NUM_GLOBAL_CTX = cci_pkg::NUM_GLOBAL_CTX_DEF,
	parameter int NUM_LOCAL_CTX  = cci_pkg::NUM_LOCAL_CTX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [cci_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [cci_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [cci_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,

	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            op,
	input  logic [cci_pkg::STORE_IDX_W-1:0] store_index,
	input  logic [cci_pkg::CTX_W-1:0]       store_value,
	input  logic                            first_slice,
	input  logic [1:0]                      slice_kind,
	input  logic signed [6:0]               slice_qp,
	input  logic                            swap_init_flag,

	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [cci_pkg::CTX_W-1:0]       context_state,
	output logic                            last_of_run,
	output logic [cci_pkg::TOTAL_W-1:0]     emitted_total
);

	localparam int MAX_N  = (NUM_GLOBAL_CTX > NUM_LOCAL_CTX) ? NUM_GLOBAL_CTX : NUM_LOCAL_CTX;
	localparam int CNT_W  = (MAX_N > 1) ? $clog2(MAX_N) : 1;
	localparam int GIDX_W = (NUM_GLOBAL_CTX > 1) ? $clog2(NUM_GLOBAL_CTX) : 1;
	localparam int LIDX_W = (NUM_LOCAL_CTX > 1) ? $clog2(NUM_LOCAL_CTX) : 1;
	localparam int FCNT_W = $clog2(cci_pkg::OUT_FIFO_DEPTH + 1);
	localparam int CRD_W  = FCNT_W + 1;

	// ---------------- config registers ----------------
	logic [cci_pkg::TABLE_W-1:0] tbl_i_q, tbl_p_q, tbl_b_q;
	cci_pkg::reg_idx_t           cfg_idx;
	logic                        cfg_wr;

	assign pready  = 1'b1;
	assign cfg_idx = cci_pkg::reg_idx_t'(paddr[cci_pkg::APB_ADDR_W-1:3]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_i_q <= '0;
			tbl_p_q <= '0;
			tbl_b_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				cci_pkg::REG_INIT_I: tbl_i_q <= pwdata;
				cci_pkg::REG_INIT_P: tbl_p_q <= pwdata;
				cci_pkg::REG_INIT_B: tbl_b_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			cci_pkg::REG_INIT_I: prdata = tbl_i_q;
			cci_pkg::REG_INIT_P: prdata = tbl_p_q;
			cci_pkg::REG_INIT_B: prdata = tbl_b_q;
			default:             prdata = '0;
		endcase
	end

	// ---------------- input decode ----------------
	logic                        in_acc, start_acc, write_acc;
	cci_pkg::reg_idx_t           sel_d;
	logic [cci_pkg::QP_W-1:0]    qp_clip;

	assign in_acc    = in_valid && in_ready;
	assign start_acc = in_acc && (op == cci_pkg::OP_START);
	assign write_acc = in_acc && (op == cci_pkg::OP_WRITE);

	// table pick; swap flag exchanges P and B, unused kind falls back to I
	always_comb begin
		unique case (cci_pkg::slice_kind_t'(slice_kind))
			cci_pkg::KIND_P: sel_d = swap_init_flag ? cci_pkg::REG_INIT_B : cci_pkg::REG_INIT_P;
			cci_pkg::KIND_B: sel_d = swap_init_flag ? cci_pkg::REG_INIT_P : cci_pkg::REG_INIT_B;
			default:         sel_d = cci_pkg::REG_INIT_I;
		endcase
	end

	always_comb begin
		if (slice_qp[6]) begin
			qp_clip = '0;
		end else if (slice_qp[5:0] > 6'(cci_pkg::QP_MAX)) begin
			qp_clip = 6'(cci_pkg::QP_MAX);
		end else begin
			qp_clip = slice_qp[5:0];
		end
	end

	// ---------------- sequencer ----------------
	cci_pkg::seq_state_t      state_q, state_d;
	logic [CNT_W-1:0]         k_q, run_last_q;
	logic                     first_q;
	cci_pkg::reg_idx_t        sel_q;
	logic [cci_pkg::QP_W-1:0] qp_q;
	logic                     issue, credit_ok, last_issue;
	logic [CRD_W-1:0]         inflight;
	logic [FCNT_W-1:0]        fifo_count;
	logic                     valid_s1, valid_s2;

	// credit: queued words plus words still in the pipe must fit the queue
	assign inflight   = CRD_W'(fifo_count) + CRD_W'(valid_s1) + CRD_W'(valid_s2);
	assign credit_ok  = int'(inflight) < cci_pkg::OUT_FIFO_DEPTH;
	assign last_issue = (k_q == run_last_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cci_pkg::ST_IDLE:  if (start_acc) state_d = cci_pkg::ST_RUN;
			cci_pkg::ST_RUN:   if (issue && last_issue) state_d = cci_pkg::ST_FLUSH;
			cci_pkg::ST_FLUSH: if (!valid_s1 && !valid_s2) state_d = cci_pkg::ST_IDLE;
			default:           state_d = cci_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		issue    = 1'b0;
		unique case (state_q)
			cci_pkg::ST_IDLE: in_ready = 1'b1;
			cci_pkg::ST_RUN:  issue    = credit_ok;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cci_pkg::ST_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (start_acc) begin
				k_q <= '0;
			end else if (issue) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_acc) begin
			run_last_q <= first_slice ? CNT_W'(NUM_LOCAL_CTX - 1) : CNT_W'(NUM_GLOBAL_CTX - 1);
			first_q    <= first_slice;
			sel_q      <= sel_d;
			qp_q       <= qp_clip;
		end
	end

	// ---------------- stage 1: store read / table byte ----------------
	logic [cci_pkg::TABLE_W-1:0] tbl_cur;
	logic [cci_pkg::CTX_W-1:0]   tbl_byte, byte_s1, store_rdata;
	logic                        last_s1, first_s1;

	always_comb begin
		unique case (sel_q)
			cci_pkg::REG_INIT_P: tbl_cur = tbl_p_q;
			cci_pkg::REG_INIT_B: tbl_cur = tbl_b_q;
			default:             tbl_cur = tbl_i_q;
		endcase
	end

	assign tbl_byte = tbl_cur[8 * k_q[LIDX_W-1:0] +: 8];

	cci_ctx_store #(
		.DEPTH (NUM_GLOBAL_CTX)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (write_acc),
		.wr_addr (store_index),
		.wr_data (store_value),
		.rd_en   (issue && !first_q),
		.rd_addr (k_q[GIDX_W-1:0]),
		.rd_data (store_rdata)
	);

	// ---------------- stage 2: multiply / replay byte ----------------
	logic                      last_s2, first_s2;
	logic [cci_pkg::CTX_W-1:0] sbyte_s2, calc_state;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		last_s1  <= last_issue;
		first_s1 <= first_q;
		byte_s1  <= tbl_byte;
		last_s2  <= last_s1;
		first_s2 <= first_s1;
		sbyte_s2 <= store_rdata;
	end

	cci_calc u_calc (
		.clk       (clk),
		.init_byte (byte_s1),
		.qp        (qp_q),
		.ctx_state (calc_state)
	);

	// ---------------- output queue ----------------
	cci_pkg::res_word_t push_word, head_word;
	logic               out_acc;

	assign push_word.ctx_state = first_s2 ? calc_state : sbyte_s2;
	assign push_word.last      = last_s2;
	assign out_acc             = out_valid && out_ready;

	cci_out_fifo #(
		.DEPTH (cci_pkg::OUT_FIFO_DEPTH)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s2),
		.push_word (push_word),
		.pop       (out_acc),
		.valid     (out_valid),
		.word      (head_word),
		.count     (fifo_count)
	);

	// total_q holds count-so-far plus one: the value shown with the next word
	logic [cci_pkg::TOTAL_W-1:0] total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= cci_pkg::TOTAL_W'(1);
		end else if (out_acc) begin
			total_q <= total_q + 1'b1;
		end
	end

	assign context_state = head_word.ctx_state;
	assign last_of_run   = head_word.last;
	assign emitted_total = total_q;

	`CCI_ASSERT_NXT(a_start_enters_run, clk, arst_n, start_acc, state_q == cci_pkg::ST_RUN, "start not followed by run")
	`CCI_ASSERT_IMP(a_idle_pipe_empty, clk, arst_n, state_q == cci_pkg::ST_IDLE, !valid_s1 && !valid_s2, "pipe busy while idle")
	`CCI_ASSERT_IMP(a_credit_bound, clk, arst_n, 1'b1, int'(inflight) <= cci_pkg::OUT_FIFO_DEPTH, "credit overrun")

endmodule

`default_nettype wire

### hw/rtl/cci_ctx_store.sv
`default_nettype none

module cci_ctx_store #(
	parameter int DEPTH = cci_pkg::NUM_GLOBAL_CTX_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [cci_pkg::STORE_IDX_W-1:0] wr_addr,
	input  logic [cci_pkg::CTX_W-1:0]       wr_data,
	input  logic                            rd_en,
	input  logic [AW-1:0]                   rd_addr,
	output logic [cci_pkg::CTX_W-1:0]       rd_data
);

	logic [cci_pkg::CTX_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]          vld_q;
	logic [cci_pkg::CTX_W-1:0] rdata_q;
	logic                      rhit_q;
	logic                      wr_hit;

	// writes past the end of the store are dropped
	assign wr_hit = wr_en && (int'(wr_addr) < DEPTH);

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			mem[wr_addr[AW-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rhit_q <= 1'b0;
		end else begin
			if (wr_hit) begin
				vld_q[wr_addr[AW-1:0]] <= 1'b1;
			end
			if (rd_en) begin
				rhit_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rhit_q ? rdata_q : '0;

endmodule

`default_nettype wire

### hw/rtl/cci_calc.sv
`default_nettype none

module cci_calc (
	input  logic                       clk,
	input  logic [cci_pkg::CTX_W-1:0]  init_byte,
	input  logic [cci_pkg::QP_W-1:0]   qp,
	output logic [cci_pkg::CTX_W-1:0]  ctx_state
);

	logic signed [7:0]  slope;
	logic signed [7:0]  offset;
	logic signed [13:0] prod_s2;
	logic signed [7:0]  off_s2;
	logic signed [9:0]  sum;
	logic [6:0]         s_clip;
	logic               mps;
	logic [5:0]         idx;

	// slope = hi*5 - 45, offset = lo*8 - 16
	always_comb begin
		slope  = $signed(8'({4'd0, init_byte[7:4]} * 8'(cci_pkg::SLOPE_MUL))
			- 8'(cci_pkg::SLOPE_BIAS));
		offset = $signed({1'b0, init_byte[3:0], 3'b000}) - 8'sd16;
	end

	always_ff @(posedge clk) begin
		prod_s2 <= 14'(slope) * 14'($signed({1'b0, qp}));
		off_s2  <= offset;
	end

	// floor(prod/16) is an arithmetic shift
	always_comb begin
		sum = 10'(prod_s2 >>> 4) + 10'(off_s2);
		if (sum < 10'(cci_pkg::STATE_MIN)) begin
			s_clip = 7'(cci_pkg::STATE_MIN);
		end else if (sum > 10'(cci_pkg::STATE_MAX)) begin
			s_clip = 7'(cci_pkg::STATE_MAX);
		end else begin
			s_clip = sum[6:0];
		end
		mps = s_clip[6];
		// s-64 above the midpoint, 63-s below it
		idx = mps ? s_clip[5:0] : ~s_clip[5:0];
		ctx_state = {idx, mps};
	end

endmodule

`default_nettype wire

### hw/rtl/cci_out_fifo.sv
`default_nettype none

`include "assert_macros.svh"

module cci_out_fifo #(
	parameter int DEPTH = cci_pkg::OUT_FIFO_DEPTH,
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  cci_pkg::res_word_t push_word,
	input  logic               pop,
	output logic               valid,
	output cci_pkg::res_word_t word,
	output logic [CW-1:0]      count
);

	cci_pkg::res_word_t slots [DEPTH];
	logic [PW-1:0]      wr_ptr_q;
	logic [PW-1:0]      rd_ptr_q;
	logic [CW-1:0]      count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign valid = (count_q != '0);
	assign word  = slots[rd_ptr_q];
	assign count = count_q;

	`CCI_ASSERT_IMP(a_fifo_no_overflow, clk, arst_n, push && !pop, int'(count_q) < DEPTH, "out fifo overflow")

endmodule

`default_nettype wire

### verif/cabac_context_initializer_test.sv
typedef struct {
	logic              op;
	logic [5:0]        store_index;
	logic [7:0]        store_value;
	logic              first_slice;
	logic [1:0]        slice_kind;
	logic signed [6:0] slice_qp;
	logic              swap_init_flag;
} ctx_word_t;

typedef struct {
	logic [7:0]  ctx;
	logic        last;
	logic [31:0] total;
} ctx_result_t;

class ctx_state_tracker;
	localparam int N_GLOBAL = cci_pkg::NUM_GLOBAL_CTX_DEF;
	localparam int N_LOCAL  = cci_pkg::NUM_LOCAL_CTX_DEF;

	logic [63:0] tbl_i, tbl_p, tbl_b;
	logic [7:0]  store [N_GLOBAL];
	logic [31:0] emitted;
	ctx_result_t due_states [$];
	int mismatches;
	int writes_seen, starts_seen, states_checked;

	function new();
		tbl_i = '0;
		tbl_p = '0;
		tbl_b = '0;
		foreach (store[i]) store[i] = '0;
		emitted = '0;
		mismatches = 0;
		writes_seen = 0;
		starts_seen = 0;
		states_checked = 0;
	endfunction

	function void set_table(int idx, logic [63:0] value);
		case (idx)
			cci_pkg::REG_INIT_I: tbl_i = value;
			cci_pkg::REG_INIT_P: tbl_p = value;
			cci_pkg::REG_INIT_B: tbl_b = value;
			default: ;
		endcase
	endfunction

	// slope/offset init of one context from its packed init byte
	function logic [7:0] init_state(int qp, logic [7:0] v);
		int slope, offset, s;
		logic mps;
		logic [6:0] idx;
		slope  = int'(v[7:4]) * cci_pkg::SLOPE_MUL - cci_pkg::SLOPE_BIAS;
		offset = int'(v[3:0]) * 8 - cci_pkg::OFFSET_BIAS;
		s = ((slope * qp) >>> 4) + offset;
		if (s < cci_pkg::STATE_MIN) s = cci_pkg::STATE_MIN;
		if (s > cci_pkg::STATE_MAX) s = cci_pkg::STATE_MAX;
		mps = (s >= 64);
		idx = mps ? 7'(s - 64) : 7'(63 - s);
		return {idx, mps};
	endfunction

	function void push_state(logic [7:0] ctx, logic last);
		ctx_result_t r;
		emitted = emitted + 32'd1;
		r.ctx = ctx;
		r.last = last;
		r.total = emitted;
		due_states.push_back(r);
	endfunction

	function void note_word(ctx_word_t w);
		int qp;
		logic [63:0] tbl;
		if (w.op == cci_pkg::OP_WRITE) begin
			writes_seen++;
			if (w.store_index < N_GLOBAL)
				store[w.store_index] = w.store_value;
			return;
		end
		starts_seen++;
		qp = int'(w.slice_qp);
		if (qp < 0) qp = 0;
		if (qp > cci_pkg::QP_MAX) qp = cci_pkg::QP_MAX;
		if (w.first_slice) begin
			case (w.slice_kind)
				cci_pkg::KIND_P: tbl = w.swap_init_flag ? tbl_b : tbl_p;
				cci_pkg::KIND_B: tbl = w.swap_init_flag ? tbl_p : tbl_b;
				default:         tbl = tbl_i;
			endcase
			for (int k = 0; k < N_LOCAL; k++)
				push_state(init_state(qp, tbl[8*k +: 8]), k == N_LOCAL - 1);
		end else begin
			for (int k = 0; k < N_GLOBAL; k++)
				push_state(store[k], k == N_GLOBAL - 1);
		end
	endfunction

	task report(string msg);
		mismatches++;
		$display("MISMATCH: %s", msg);
	endtask

	task check_state(logic [7:0] ctx, logic last, logic [31:0] total);
		ctx_result_t r;
		if (due_states.size() == 0) begin
			report($sformatf("unexpected word ctx=%h last=%b total=%0d", ctx, last, total));
			return;
		end
		r = due_states.pop_front();
		states_checked++;
		if (ctx !== r.ctx)
			report($sformatf("context_state %h, want %h (total %0d)", ctx, r.ctx, r.total));
		if (last !== r.last)
			report($sformatf("last_of_run %b, want %b (total %0d)", last, r.last, r.total));
		if (total !== r.total)
			report($sformatf("emitted_total %0d, want %0d", total, r.total));
	endtask
endclass

module cabac_context_initializer_test;

	localparam int LIMIT = 400_000;
	// drain after the last word, covers the result pipe and its flush
	localparam int SETTLE = 8;
	localparam int REG_UNMAPPED = 3;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int RANDOM_PHASES = 5;
	localparam int WORDS_PER_PHASE = 70;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                           psel = 1'b0;
	logic                           penable = 1'b0;
	logic                           pwrite = 1'b0;
	logic [cci_pkg::APB_ADDR_W-1:0] paddr = '0;
	logic [cci_pkg::APB_DATA_W-1:0] pwdata = '0;
	logic [cci_pkg::APB_DATA_W-1:0] prdata;
	logic                           pready;

	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              op = cci_pkg::OP_WRITE;
	logic [5:0]        store_index = '0;
	logic [7:0]        store_value = '0;
	logic              first_slice = 1'b0;
	logic [1:0]        slice_kind = '0;
	logic signed [6:0] slice_qp = '0;
	logic              swap_init_flag = 1'b0;

	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  context_state;
	logic        last_of_run;
	logic [31:0] emitted_total;

	// calm = both sides run flat out, no random idling
	logic calm = 1'b0;
	int cycles = 0;
	ctx_state_tracker tracker;

	cabac_context_initializer dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .op(op),
		.store_index(store_index), .store_value(store_value),
		.first_slice(first_slice), .slice_kind(slice_kind), .slice_qp(slice_qp),
		.swap_init_flag(swap_init_flag),
		.out_valid(out_valid), .out_ready(out_ready), .context_state(context_state),
		.last_of_run(last_of_run), .emitted_total(emitted_total)
	);

	always #1 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("timeout after %0d cycles, %0d states still due", cycles,
				tracker.due_states.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// sink back-pressure: ~19% stall cycles unless in a calm stretch
	always @(posedge clk) begin
		out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 19);
	end

	// Everything only changes at rising edges, so the handshake seen at the
	// falling edge is exactly what the next rising edge will take.
	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_state(context_state, last_of_run, emitted_total);
	end

	// APB write: setup, then access; pready is checked on the access edge.
	// Called at a rising edge, returns at the next edge after the one that wrote
	// the register, with the bus idle.
	task automatic apb_write(input int idx, input logic [63:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= cci_pkg::APB_ADDR_W'(idx * 8);
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		tracker.set_table(idx, data);
		@(posedge clk);
	endtask

	task automatic load_tables(input logic [63:0] ti, input logic [63:0] tp,
			input logic [63:0] tb);
		apb_write(cci_pkg::REG_INIT_I, ti);
		apb_write(cci_pkg::REG_INIT_P, tp);
		apb_write(cci_pkg::REG_INIT_B, tb);
	endtask

	// Present one word and hold it until taken. Random idle cycles go in
	// front; they only lower valid, never mid-word.
	task automatic send_word(input ctx_word_t w);
		while (!calm && $urandom_range(99) < 19) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= w.op;
		store_index <= w.store_index;
		store_value <= w.store_value;
		first_slice <= w.first_slice;
		slice_kind <= w.slice_kind;
		slice_qp <= w.slice_qp;
		swap_init_flag <= w.swap_init_flag;
		do @(negedge clk); while (!in_ready);
		tracker.note_word(w);
		@(posedge clk);
	endtask

	// Block idle: input dropped, every due state seen, pipe drained.
	task automatic settle();
		in_valid <= 1'b0;
		while (tracker.due_states.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// ignored fields are filled with noise on purpose
	function automatic ctx_word_t noise_word();
		ctx_word_t w;
		w.op = cci_pkg::OP_WRITE;
		w.store_index = 6'($urandom);
		w.store_value = 8'($urandom);
		w.first_slice = 1'($urandom);
		w.slice_kind = 2'($urandom);
		w.slice_qp = 7'($urandom);
		w.swap_init_flag = 1'($urandom);
		return w;
	endfunction

	function automatic ctx_word_t store_word(input logic [5:0] idx, input logic [7:0] val);
		ctx_word_t w;
		w = noise_word();
		w.op = cci_pkg::OP_WRITE;
		w.store_index = idx;
		w.store_value = val;
		return w;
	endfunction

	function automatic ctx_word_t start_word(input logic first, input logic [1:0] kind,
			input logic signed [6:0] qp, input logic swap);
		ctx_word_t w;
		w = noise_word();
		w.op = cci_pkg::OP_START;
		w.first_slice = first;
		w.slice_kind = kind;
		w.slice_qp = qp;
		w.swap_init_flag = swap;
		return w;
	endfunction

	// Random mix: mostly in-range store writes, about a third slice starts.
	// QP lands in 0..51 half the time, anywhere in the 7-bit range otherwise.
	function automatic ctx_word_t random_word();
		ctx_word_t w;
		logic signed [6:0] qp;
		if ($urandom_range(99) < 35) begin
			qp = $urandom_range(1) ? 7'($urandom_range(cci_pkg::QP_MAX)) : 7'($urandom);
			w = start_word(($urandom_range(99) < 60), 2'($urandom), qp, 1'($urandom));
		end else if ($urandom_range(99) < 85) begin
			w = store_word(6'($urandom_range(cci_pkg::NUM_GLOBAL_CTX_DEF - 1)),
				8'($urandom));
		end else begin
			w = store_word(6'($urandom_range(63, cci_pkg::NUM_GLOBAL_CTX_DEF)),
				8'($urandom));
		end
		return w;
	endfunction

	initial begin
		tracker = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Tables still at reset: replay of the cleared store and a first
		// slice off an all-zero table.
		send_word(start_word(1'b0, cci_pkg::KIND_I, 7'sd26, 1'b0));
		send_word(start_word(1'b1, cci_pkg::KIND_I, 7'sd0, 1'b0));
		settle();

		// Extreme tables; the write to the unmapped slot must be dropped.
		load_tables({8{8'hFF}}, 64'h0, 64'h9A5C_3EF0_0F7D_41C8);
		apb_write(REG_UNMAPPED, 64'hDEAD_BEEF_0123_4567);

		// store edges, writes past the store end, then replay
		send_word(store_word(6'd0, 8'hFF));
		send_word(store_word(6'd31, 8'h80));
		send_word(store_word(6'd32, 8'h55));
		send_word(store_word(6'd63, 8'hAA));
		send_word(store_word(6'd5, 8'h00));
		send_word(store_word(6'd17, 8'h3C));
		send_word(start_word(1'b0, cci_pkg::KIND_P, 7'sd30, 1'b1));
		// QP extremes and clipping, each slice kind, swap on and off;
		// 7'h40 is the most negative QP
		send_word(start_word(1'b1, cci_pkg::KIND_I, 7'h40, 1'b0));
		send_word(start_word(1'b1, cci_pkg::KIND_I, 7'sd63, 1'b0));
		send_word(start_word(1'b1, cci_pkg::KIND_P, 7'sd51, 1'b0));
		send_word(start_word(1'b1, cci_pkg::KIND_P, 7'sd52, 1'b1));
		send_word(start_word(1'b1, cci_pkg::KIND_B, 7'sd0, 1'b0));
		send_word(start_word(1'b1, cci_pkg::KIND_B, -7'sd1, 1'b1));
		send_word(start_word(1'b1, KIND_UNUSED, 7'sd20, 1'b1));
		send_word(start_word(1'b1, cci_pkg::KIND_P, 7'sd25, 1'b0));
		send_word(start_word(1'b1, cci_pkg::KIND_B, 7'sd37, 1'b1));
		settle();

		// Random phases, new tables for each; phase 1 uses all-zero/all-one
		// tables, phase 3 runs with no idling on either side.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 1)
				load_tables(64'h0, {8{8'hFF}}, {8{8'hFF}});
			else
				load_tables({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
			calm <= (p == 3);
			for (int n = 0; n < WORDS_PER_PHASE; n++)
				send_word(random_word());
			settle();
		end

		repeat (SETTLE) @(posedge clk);
		$display("covered %0d store writes and %0d slice starts over %0d table settings,",
			tracker.writes_seen, tracker.starts_seen, RANDOM_PHASES + 2);
		$display("%0d context states checked in %0d cycles", tracker.states_checked, cycles);
		if (tracker.mismatches == 0 && tracker.due_states.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
